FILE: hw/rtl/dit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_pkg - shared types and constants of the disjoint interval tracker
// Table geometry, result status codes, opcodes and the table entry layout.
// ----------------------------------------------------------------------------
package dit_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int VALUE_BITS    = 16;

    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * VALUE_BITS + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);

    typedef enum logic [2:0] {
        ST_COVERED = 3'd0,
        ST_LEFT    = 3'd1,
        ST_RIGHT   = 3'd2,
        ST_BRIDGE  = 3'd3,
        ST_NEW     = 3'd4,
        ST_FULL    = 3'd5,
        ST_ENTRY   = 3'd6,
        ST_EMPTY   = 3'd7
    } t_status;

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_LIST = 1'b1
    } t_op;

    // hi = last value, lo = first value
    typedef struct packed {
        logic [VALUE_BITS-1:0] hi;
        logic [VALUE_BITS-1:0] lo;
    } t_entry;

endpackage

FILE: hw/rtl/disjoint_interval_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disjoint_interval_tracker_unit - sorted table of disjoint closed intervals
// Tracks each value added as a set of non-touching intervals while the table has room, and lists them.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel s_axis: tuser[0] = operation (0 add, 1 list),
//   tdata = value. Result channel m_axis: tuser = status, tdata holds
//   range_start (low) and range_end (high), tlast marks the final result.
//   An add scans the table one entry a cycle through the table RAM read
//   port, then decides; a bridge or a new interval moves the following
//   entries one a cycle through the same RAM. A list reads the first entry
//   from the registered RAM port, then gives one result a cycle while the
//   receiver takes them; an empty table gives a single result.
//   s_axis_tready is high only while the unit is idle, one request at a time.
//   The result sits in an output register; a stalled receiver holds the unit
//   until the register frees, but an idle unit still takes a new request.
//   Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
module disjoint_interval_tracker_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dit_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // value
    input  logic [0:0]                      s_axis_tuser,  // operation
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dit_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // range_start, range_end
    output logic [2:0]                      m_axis_tuser,  // status
    output logic                            m_axis_tlast   // last
);

    localparam int VB    = dit_pkg::VALUE_BITS;
    localparam int IDX_W = dit_pkg::IDX_W;
    localparam int CNT_W = dit_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_PUT,
        S_LIST
    } t_state;

    t_state             r_state;
    logic [VB-1:0]      r_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_new_count;
    logic [CNT_W-1:0]   r_issue;
    logic               r_chk_v;
    logic [CNT_W-1:0]   r_cnt_le;
    dit_pkg::t_entry    r_left;
    dit_pkg::t_entry    r_right;
    logic               r_has_right;
    logic [CNT_W-1:0]   r_sh;
    logic               r_sh_up;
    logic               r_wv;
    logic [IDX_W-1:0]   r_wa;
    dit_pkg::t_status   r_res_status;
    dit_pkg::t_entry    r_res;
    logic               r_m_valid;
    dit_pkg::t_status   r_m_status;
    dit_pkg::t_entry    r_m_data;
    logic               r_m_last;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    dit_pkg::t_entry    ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [$bits(dit_pkg::t_entry)-1:0] ram_rd_raw;
    dit_pkg::t_entry    rd;

    logic               slot_free;
    logic               m_load;
    logic               in_req;
    logic               in_list;
    logic               has_left;
    logic               covered;
    logic               left_adj;
    logic               right_adj;
    dit_pkg::t_status   d_kind;
    logic [CNT_W-1:0]   im1_cnt;
    logic [IDX_W-1:0]   i_idx;
    logic [IDX_W-1:0]   im1_idx;
    logic               scan_hit;
    logic               scan_end;
    logic               scan_issue;
    logic               sh_issue;
    logic [CNT_W-1:0]   sh_src;
    logic [CNT_W-1:0]   sh_dst;
    logic               sh_done;
    logic               list_last;
    dit_pkg::t_entry    vv;

    dit_ram #(
        .DEPTH (dit_pkg::MAX_INTERVALS),
        .WIDTH ($bits(dit_pkg::t_entry)),
        .AW    (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_raw)
    );

    assign rd = dit_pkg::t_entry'(ram_rd_raw);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = dit_pkg::OUT_DATA_W'(r_m_data);
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

    assign slot_free = !r_m_valid || m_axis_tready;
    assign m_load    = slot_free && ((r_state == S_PUT) || (r_state == S_LIST));
    assign in_req    = s_axis_tvalid && (r_state == S_IDLE);
    assign in_list   = (dit_pkg::t_op'(s_axis_tuser) == dit_pkg::OP_LIST);
    assign vv        = '{hi: r_value, lo: r_value};

    // decision on the neighbors found by the scan
    assign has_left  = (r_cnt_le != '0);
    assign covered   = has_left && (r_value <= r_left.hi);
    assign left_adj  = has_left && (({1'b0, r_left.hi} + (VB+1)'(1)) == {1'b0, r_value});
    assign right_adj = r_has_right && ({1'b0, r_right.lo} == ({1'b0, r_value} + (VB+1)'(1)));
    assign im1_cnt   = r_cnt_le - CNT_W'(1);
    assign im1_idx   = im1_cnt[IDX_W-1:0];
    assign i_idx     = r_cnt_le[IDX_W-1:0];

    always_comb begin
        if (covered) begin
            d_kind = dit_pkg::ST_COVERED;
        end else if (left_adj && right_adj) begin
            d_kind = dit_pkg::ST_BRIDGE;
        end else if (left_adj) begin
            d_kind = dit_pkg::ST_LEFT;
        end else if (right_adj) begin
            d_kind = dit_pkg::ST_RIGHT;
        end else if (r_count >= dit_pkg::MAX_CNT) begin
            d_kind = dit_pkg::ST_FULL;
        end else begin
            d_kind = dit_pkg::ST_NEW;
        end
    end

    // scan: issue one read a cycle, compare the previous read
    assign scan_hit   = r_chk_v && (rd.lo > r_value);
    assign scan_end   = !r_chk_v && (r_issue == r_count);
    assign scan_issue = (r_issue < r_count) && !scan_hit;

    // move: up closes a gap after a bridge, down opens one for a new entry
    assign sh_issue = r_sh_up ? (r_sh < r_count) : (r_sh > r_cnt_le);
    assign sh_src   = r_sh_up ? r_sh : (r_sh - CNT_W'(1));
    assign sh_dst   = r_sh_up ? (r_sh - CNT_W'(1)) : r_sh;
    assign sh_done  = !sh_issue && !r_wv;

    assign list_last = ((r_sh + CNT_W'(1)) == r_count);

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = vv;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_req && in_list && (r_count != '0)) begin
                    ram_rd_en = 1'b1;
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_issue[IDX_W-1:0];
                end
            end
            S_DECIDE: begin
                unique case (d_kind)
                    dit_pkg::ST_BRIDGE: begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = im1_idx;
                        ram_wr_data = '{hi: r_right.hi, lo: r_left.lo};
                    end
                    dit_pkg::ST_LEFT: begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = im1_idx;
                        ram_wr_data = '{hi: r_value, lo: r_left.lo};
                    end
                    dit_pkg::ST_RIGHT: begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = i_idx;
                        ram_wr_data = '{hi: r_right.hi, lo: r_value};
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                if (sh_issue) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = sh_src[IDX_W-1:0];
                end
                if (r_wv) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_wa;
                    ram_wr_data = rd;
                end else if (sh_done && !r_sh_up) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = i_idx;
                    ram_wr_data = vv;
                end
            end
            S_LIST: begin
                if (slot_free && !list_last) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = IDX_W'(r_sh + CNT_W'(1));
                end
            end
            S_PUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chk_v   <= 1'b0;
            r_wv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && !m_load) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_req) begin
                        r_value  <= s_axis_tdata[VB-1:0];
                        r_issue  <= '0;
                        r_chk_v  <= 1'b0;
                        r_cnt_le <= '0;
                        r_sh     <= '0;
                        if (!in_list) begin
                            r_state <= S_SCAN;
                        end else if (r_count == '0) begin
                            r_res_status <= dit_pkg::ST_EMPTY;
                            r_res        <= '0;
                            r_state      <= S_PUT;
                        end else begin
                            r_state <= S_LIST;
                        end
                    end
                end
                S_SCAN: begin
                    r_chk_v <= scan_issue;
                    if (scan_issue) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    if (scan_hit) begin
                        r_right     <= rd;
                        r_has_right <= 1'b1;
                        r_state     <= S_DECIDE;
                    end else if (r_chk_v) begin
                        r_left   <= rd;
                        r_cnt_le <= r_cnt_le + CNT_W'(1);
                    end else if (scan_end) begin
                        r_has_right <= 1'b0;
                        r_state     <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res_status <= d_kind;
                    r_wv         <= 1'b0;
                    unique case (d_kind)
                        dit_pkg::ST_COVERED: begin
                            r_res   <= r_left;
                            r_state <= S_PUT;
                        end
                        dit_pkg::ST_BRIDGE: begin
                            r_res       <= '{hi: r_right.hi, lo: r_left.lo};
                            r_sh        <= r_cnt_le + CNT_W'(1);
                            r_sh_up     <= 1'b1;
                            r_new_count <= r_count - CNT_W'(1);
                            r_state     <= S_SHIFT;
                        end
                        dit_pkg::ST_LEFT: begin
                            r_res   <= '{hi: r_value, lo: r_left.lo};
                            r_state <= S_PUT;
                        end
                        dit_pkg::ST_RIGHT: begin
                            r_res   <= '{hi: r_right.hi, lo: r_value};
                            r_state <= S_PUT;
                        end
                        dit_pkg::ST_FULL: begin
                            r_res   <= vv;
                            r_state <= S_PUT;
                        end
                        default: begin
                            r_res       <= vv;
                            r_sh        <= r_count;
                            r_sh_up     <= 1'b0;
                            r_new_count <= r_count + CNT_W'(1);
                            r_state     <= S_SHIFT;
                        end
                    endcase
                end
                S_SHIFT: begin
                    r_wv <= sh_issue;
                    if (sh_issue) begin
                        r_wa <= sh_dst[IDX_W-1:0];
                        r_sh <= r_sh_up ? (r_sh + CNT_W'(1)) : (r_sh - CNT_W'(1));
                    end
                    if (sh_done) begin
                        r_count <= r_new_count;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (slot_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_res_status;
                        r_m_data   <= r_res;
                        r_m_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_LIST: begin
                    if (slot_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= dit_pkg::ST_ENTRY;
                        r_m_data   <= rd;
                        r_m_last   <= list_last;
                        r_sh       <= r_sh + CNT_W'(1);
                        if (list_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dit_pkg::MAX_CNT)
        else $error("interval count above table size");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CNT_W'(1)) ||
             (r_count == $past(r_count) - CNT_W'(1))))
        else $error("interval count moved by more than one");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != dit_pkg::ST_ENTRY)) |-> m_axis_tlast)
        else $error("single result without last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (r_state == S_SHIFT))
        else $error("entry move pending outside move phase");

endmodule

FILE: hw/rtl/dit_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dit_ram - simple dual-port RAM
// One write port and one read port; read data registered on read enable.
// ----------------------------------------------------------------------------
module dit_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for disjoint_interval_tracker_unit
// Sends add and list requests over s_axis and keeps a software copy of the
// interval table. From that copy it works out the status and interval of
// every result, then checks each result on m_axis in order, field by field.
// The stimulus fills the table, overflows it and merges entries again, with
// random stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 60;
    localparam int DRAIN_CYCLES    = 80;
    localparam int VB              = dit_pkg::VALUE_BITS;
    localparam int IN_W            = dit_pkg::IN_DATA_W;
    localparam int OUT_W           = dit_pkg::OUT_DATA_W;

    typedef struct {
        dit_pkg::t_op          op;
        logic [VB-1:0]         value;
        bit                    drain_first;
        bit                    settle;
    } t_request;

    typedef struct {
        dit_pkg::t_status      status;
        logic [VB-1:0]         lo;
        logic [VB-1:0]         hi;
        logic                  last;
    } t_span_report;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata  = '0;  // value
    logic [0:0]             s_axis_tuser  = '0;  // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       m_axis_tdata;        // range_start, range_end
    logic [2:0]             m_axis_tuser;        // status
    logic                   m_axis_tlast;

    t_request               request_backlog[$];
    t_span_report           span_reports_due[$];

    logic [VB-1:0]          span_lo[dit_pkg::MAX_INTERVALS];
    logic [VB-1:0]          span_hi[dit_pkg::MAX_INTERVALS];
    int                     span_count = 0;

    logic                   req_taken     = 1'b0;
    bit                     calm          = 1'b0;
    bit                     hold_done     = 1'b0;
    int                     hold_left     = 0;
    int                     rx_gap        = 0;
    int                     rx_quiet      = 0;
    int                     tx_gap        = 0;
    int                     idle_cycles   = 0;
    int                     mismatches    = 0;
    int                     requests_queued = 0;
    int                     requests_taken  = 0;
    int                     results_seen    = 0;
    int                     status_hits[8];

    disjoint_interval_tracker_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic void push_report(dit_pkg::t_status st, logic [VB-1:0] lo,
                                        logic [VB-1:0] hi, logic last);
        t_span_report r;
        r.status = st;
        r.lo     = lo;
        r.hi     = hi;
        r.last   = last;
        span_reports_due = {span_reports_due, r};
    endfunction

    // updates the table copy and queues the results one request causes
    function automatic void track_request(dit_pkg::t_op op, logic [VB-1:0] v);
        int  n;
        int  i;
        bit  left_adj;
        bit  right_adj;
        n = span_count;
        i = 0;
        if (op == dit_pkg::OP_LIST) begin
            if (n == 0)
                push_report(dit_pkg::ST_EMPTY, '0, '0, 1'b1);
            for (int k = 0; k < n; k++)
                push_report(dit_pkg::ST_ENTRY, span_lo[k], span_hi[k], k == n - 1);
            return;
        end
        while (i < n && span_lo[i] <= v)
            i++;
        if (i > 0 && v <= span_hi[i-1]) begin
            push_report(dit_pkg::ST_COVERED, span_lo[i-1], span_hi[i-1], 1'b1);
            return;
        end
        left_adj  = (i > 0) && (int'(span_hi[i-1]) + 1 == int'(v));
        right_adj = (i < n) && (int'(span_lo[i]) == int'(v) + 1);
        if (left_adj && right_adj) begin
            span_hi[i-1] = span_hi[i];
            for (int j = i; j + 1 < n; j++) begin
                span_lo[j] = span_lo[j+1];
                span_hi[j] = span_hi[j+1];
            end
            span_count = n - 1;
            push_report(dit_pkg::ST_BRIDGE, span_lo[i-1], span_hi[i-1], 1'b1);
        end else if (left_adj) begin
            span_hi[i-1] = v;
            push_report(dit_pkg::ST_LEFT, span_lo[i-1], v, 1'b1);
        end else if (right_adj) begin
            span_lo[i] = v;
            push_report(dit_pkg::ST_RIGHT, v, span_hi[i], 1'b1);
        end else if (n >= dit_pkg::MAX_INTERVALS) begin
            push_report(dit_pkg::ST_FULL, v, v, 1'b1);
        end else begin
            for (int j = n; j > i; j--) begin
                span_lo[j] = span_lo[j-1];
                span_hi[j] = span_hi[j-1];
            end
            span_lo[i] = v;
            span_hi[i] = v;
            span_count = n + 1;
            push_report(dit_pkg::ST_NEW, v, v, 1'b1);
        end
    endfunction

    function automatic void queue_request(dit_pkg::t_op op, int value,
                                          bit drain_first = 1'b0, bit settle = 1'b0);
        t_request r;
        r.op          = op;
        r.value       = value[VB-1:0];
        r.drain_first = drain_first;
        r.settle      = settle;
        request_backlog = {request_backlog, r};
        requests_queued++;
    endfunction

    function automatic void report_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    // request driver
    always @(negedge i_clk) begin : driver
        t_request              item;
        logic                  nv;
        logic [IN_W-1:0]       nd;
        logic [0:0]            nu;
        if (i_rst_n && !(s_axis_tvalid && !req_taken)) begin
            nv = 1'b0;
            nd = IN_W'($urandom);
            nu = 1'($urandom);
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (request_backlog.size() > 0 &&
                         !(request_backlog[0].drain_first &&
                           span_reports_due.size() != 0)) begin
                item = request_backlog.pop_front();
                nv = 1'b1;
                nd = IN_W'(item.value);
                nu = item.op;
                if (item.settle)
                    calm = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    tx_gap = $urandom_range(1, 12);
            end
            s_axis_tvalid <= nv;
            s_axis_tdata  <= nd;
            s_axis_tuser  <= nu;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin : receiver
        logic ready;
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            ready = 1'b0;
        end else begin
            ready = 1'b1;
            if (rx_quiet > 0) begin
                rx_quiet--;
            end else if (!calm) begin
                if ($urandom_range(0, 19) == 0)
                    rx_quiet = $urandom_range(20, 60);
                else if ($urandom_range(0, 5) == 0)
                    rx_gap = $urandom_range(1, 12);
            end
        end
        m_axis_tready <= ready;
    end

    // accepts requests into the predictor and checks results
    always @(posedge i_clk) begin : monitor
        t_span_report           want;
        logic [VB-1:0]          got_lo;
        logic [VB-1:0]          got_hi;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                track_request(dit_pkg::t_op'(s_axis_tuser), s_axis_tdata[VB-1:0]);
                requests_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_lo = m_axis_tdata[VB-1:0];
                got_hi = m_axis_tdata[2*VB-1:VB];
                results_seen++;
                status_hits[m_axis_tuser]++;
                if (span_reports_due.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result: status %0d [%0d,%0d] last %0b",
                        m_axis_tuser, got_lo, got_hi, m_axis_tlast));
                end else begin
                    want = span_reports_due.pop_front();
                    if (m_axis_tuser !== want.status || got_lo !== want.lo ||
                        got_hi !== want.hi || m_axis_tlast !== want.last)
                        report_mismatch($sformatf(
                            {"mismatch: expected status %0d [%0d,%0d] last %0b, ",
                             "got %0d [%0d,%0d] last %0b"},
                            want.status, want.lo, want.hi, want.last,
                            m_axis_tuser, got_lo, got_hi, m_axis_tlast));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin : watchdog
        wait (i_rst_n);
        while (idle_cycles < WATCHDOG_CYCLES)
            @(posedge i_clk);
        $display("disjoint_interval_tracker_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int slots[40];
        int k;
        int tmp;
        int r;

        foreach (status_hits[s])
            status_hits[s] = 0;

        // directed: empty list, both ends of the value range, each add outcome but full
        queue_request(dit_pkg::OP_LIST, 0);
        queue_request(dit_pkg::OP_ADD, 0);
        queue_request(dit_pkg::OP_ADD, 0);
        queue_request(dit_pkg::OP_ADD, 65535);
        queue_request(dit_pkg::OP_ADD, 65534);
        queue_request(dit_pkg::OP_ADD, 2);
        queue_request(dit_pkg::OP_ADD, 1);
        queue_request(dit_pkg::OP_ADD, 3);
        queue_request(dit_pkg::OP_ADD, 200);
        queue_request(dit_pkg::OP_ADD, 198);
        queue_request(dit_pkg::OP_ADD, 199);
        queue_request(dit_pkg::OP_LIST, 16'hffff);
        queue_request(dit_pkg::OP_ADD, 65533);
        queue_request(dit_pkg::OP_ADD, 65535);
        queue_request(dit_pkg::OP_LIST, 16'h5a5a);

        // dense window: lots of extends and merges, some lists and stray values
        for (int n = 0; n < 50; n++) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                queue_request(dit_pkg::OP_LIST, $urandom_range(0, 65535), n == 0);
            else if (r < 17)
                queue_request(dit_pkg::OP_ADD, $urandom_range(0, 65535), n == 0);
            else
                queue_request(dit_pkg::OP_ADD, 1000 + $urandom_range(0, 63), n == 0);
        end

        // spaced values in shuffled order push the table past full
        foreach (slots[s])
            slots[s] = s;
        for (int s = 39; s > 0; s--) begin
            k = $urandom_range(0, s);
            tmp = slots[s];
            slots[s] = slots[k];
            slots[k] = tmp;
        end
        for (int s = 0; s < 40; s++) begin
            queue_request(dit_pkg::OP_ADD, 20000 + 2 * slots[s], s == 0);
            if (s % 10 == 9)
                queue_request(dit_pkg::OP_LIST, $urandom_range(0, 65535));
        end
        queue_request(dit_pkg::OP_LIST, 0);

        // closing the gaps merges entries again; no idling from here on
        for (int n = 0; n < 40; n++) begin
            if (n % 6 == 5)
                queue_request(dit_pkg::OP_LIST, $urandom_range(0, 65535), n == 0, 1'b1);
            else if (n % 7 == 3)
                queue_request(dit_pkg::OP_ADD, 1000 + $urandom_range(0, 63), n == 0, 1'b1);
            else
                queue_request(dit_pkg::OP_ADD, 20001 + 2 * $urandom_range(0, 38),
                              n == 0, 1'b1);
        end
        queue_request(dit_pkg::OP_LIST, 0, 1'b0, 1'b1);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (requests_taken == requests_queued);
        wait (span_reports_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results: covered %0d, left %0d, right %0d, bridged %0d,",
                 requests_taken, results_seen, status_hits[dit_pkg::ST_COVERED],
                 status_hits[dit_pkg::ST_LEFT], status_hits[dit_pkg::ST_RIGHT],
                 status_hits[dit_pkg::ST_BRIDGE]);
        $display("new %0d, full %0d, list entries %0d, empty lists %0d; %0d mismatches",
                 status_hits[dit_pkg::ST_NEW], status_hits[dit_pkg::ST_FULL],
                 status_hits[dit_pkg::ST_ENTRY], status_hits[dit_pkg::ST_EMPTY],
                 mismatches);
        if (mismatches == 0 && span_reports_due.size() == 0) begin
            $display("disjoint_interval_tracker_unit test passed");
        end else begin
            $display("disjoint_interval_tracker_unit test failed");
        end
        $finish;
    end

endmodule
